FILE: hdl/assert_macros.svh
// Assertion macros shared by the receiver, transmitter, FIFO and top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/uartpm_pkg.sv
// Shared types, codes and reset values of the UART with receive FIFO and pulse meter.
package uartpm_pkg;

  localparam int FIFO_DEPTH_DEF = 64;
  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_W-1:0] RX_CENTER_RST = 16'd50;
  localparam logic [CFG_W-1:0] RX_BIT_RST    = 16'd114;
  localparam logic [CFG_W-1:0] RX_STOP_RST   = 16'd114;
  localparam logic [CFG_W-1:0] TX_BIT_RST    = 16'd112;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_ENABLE    = 3'd0,
    CFG_RX_CENTER    = 3'd1,
    CFG_RX_BIT       = 3'd2,
    CFG_RX_STOP      = 3'd3,
    CFG_TX_BIT       = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic             rx_enable;
    logic [CFG_W-1:0] rx_center_ticks;
    logic [CFG_W-1:0] rx_bit_ticks;
    logic [CFG_W-1:0] rx_stop_ticks;
    logic [CFG_W-1:0] tx_bit_ticks;
  } cfg_t;

  typedef struct packed {
    logic       rx_line;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       pop_req;
    logic       clear_overflow;
    logic       flush;
    logic       take_width;
  } in_item_t;

  typedef struct packed {
    logic        tx_line;
    logic        tx_accepted;
    logic        tx_busy;
    logic [7:0]  rx_data;
    logic        rx_empty;
    logic [5:0]  rx_count;
    logic        overflow;
    logic [15:0] pulse_width;
    logic        pulse_ready;
  } out_item_t;

  typedef struct packed {
    logic pop_req;
    logic flush;
    logic clear_overflow;
  } host_ctrl_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } push_t;

  typedef struct packed {
    logic [7:0] rx_data;
    logic       rx_empty;
    logic [5:0] rx_count;
    logic       overflow;
  } fifo_status_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        pulse_ready;
  } meter_t;

  typedef struct packed {
    logic tx_line;
    logic tx_accepted;
    logic tx_busy;
  } tx_status_t;

endpackage

FILE: hdl/uartpm_in_if.sv
// Tick channel: one sampled line level and host request set per item.
interface uartpm_in_if import uartpm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/uartpm_out_if.sv
// Result channel: line, FIFO and meter status after each tick.
interface uartpm_out_if import uartpm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/uartpm_rx.sv
// 8N1 receiver and long-low-pulse meter, one tick per accepted item.
`include "assert_macros.svh"

module uartpm_rx import uartpm_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   fire,
  input  logic   rx_line,
  input  logic   take_width,
  input  cfg_t   cfg,
  output push_t  push,
  output meter_t meter
);

  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] timer, timer_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift, shift_next;
  logic                  measuring, measuring_next;
  logic [TIMER_BITS-1:0] width_timer, width_timer_next;
  logic [TIMER_BITS-1:0] width_hold, width_hold_next;
  logic                  width_ready, width_ready_next;

  logic                  meas_mid;
  logic [TIMER_BITS-1:0] wt_mid;
  logic                  start;
  logic                  timer_done;

  // Meter runs ahead of the receiver within a tick
  always_comb begin
    width_ready_next = take_width ? 1'b0 : width_ready;
    width_hold_next  = width_hold;
    meas_mid         = measuring;
    wt_mid           = width_timer;
    if ((measuring || phase != PH_IDLE) && width_timer != TMAX) begin
      wt_mid = width_timer + 1'b1;
    end
    if (measuring && rx_line) begin
      width_hold_next  = wt_mid;
      width_ready_next = 1'b1;
      meas_mid         = 1'b0;
    end
  end

  assign start      = (phase == PH_IDLE) && cfg.rx_enable && !rx_line && !meas_mid;
  assign timer_done = (timer[TIMER_BITS-1:1] == '0);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE:  if (start) phase_next = PH_FIRST;
      PH_FIRST: if (timer_done) phase_next = PH_DATA;
      PH_DATA:  if (timer_done && bit_index == 3'd7) phase_next = PH_STOP;
      PH_STOP:  if (timer_done) phase_next = PH_IDLE;
      default:  phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    timer_next       = timer;
    bit_index_next   = bit_index;
    shift_next       = shift;
    measuring_next   = meas_mid;
    width_timer_next = wt_mid;
    push             = '0;
    unique case (phase)
      PH_IDLE: begin
        if (start) begin
          timer_next       = TIMER_BITS'(cfg.rx_center_ticks);
          bit_index_next   = '0;
          shift_next       = '0;
          width_timer_next = '0;
        end
      end
      PH_FIRST: begin
        if (timer_done) begin
          bit_index_next = '0;
          timer_next     = TIMER_BITS'(cfg.rx_bit_ticks);
        end else begin
          timer_next = timer - 1'b1;
        end
      end
      PH_DATA: begin
        if (timer_done) begin
          if (rx_line) shift_next[bit_index] = 1'b1;
          if (bit_index == 3'd7) begin
            timer_next = TIMER_BITS'(cfg.rx_stop_ticks);
          end else begin
            bit_index_next = bit_index + 1'b1;
            timer_next     = TIMER_BITS'(cfg.rx_bit_ticks);
          end
        end else begin
          timer_next = timer - 1'b1;
        end
      end
      PH_STOP: begin
        if (timer_done) begin
          // A low stop sample still delivers the byte, then times the pulse
          push.valid     = 1'b1;
          push.data      = shift;
          bit_index_next = '0;
          if (!rx_line) measuring_next = 1'b1;
        end else begin
          timer_next = timer - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      timer       <= '0;
      bit_index   <= '0;
      shift       <= '0;
      measuring   <= 1'b0;
      width_timer <= '0;
      width_hold  <= '0;
      width_ready <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      timer       <= timer_next;
      bit_index   <= bit_index_next;
      shift       <= shift_next;
      measuring   <= measuring_next;
      width_timer <= width_timer_next;
      width_hold  <= width_hold_next;
      width_ready <= width_ready_next;
    end
  end

  assign meter.pulse_width = 16'(width_hold);
  assign meter.pulse_ready = width_ready;

  `ASSERT_IMPL(a_meter_only_idle, measuring, phase == PH_IDLE, "pulse meter running during a frame")
  `ASSERT_IMPL(a_ready_on_rise, $rose(width_ready), $past(fire && measuring && rx_line), "pulse ready without a rising line")

endmodule

FILE: hdl/uartpm_fifo.sv
// Receive ring FIFO with one spare slot, sticky overflow and registered head read.
`include "assert_macros.svh"

module uartpm_fifo import uartpm_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         fire,
  input  host_ctrl_t   host,
  input  push_t        push,
  output fifo_status_t status
);

  localparam int                PTR_W   = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0]  LAST    = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [PTR_W:0]    DEPTH_W = (PTR_W + 1)'(FIFO_DEPTH);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [7:0]       rd_data;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic             overflow_flag, overflow_next;
  logic [PTR_W-1:0] head_mid, tail_mid;
  logic             push_ok;
  logic [PTR_W:0]   count;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  // Flush beats pop; the push then sees the updated pointers
  always_comb begin
    if (host.flush) begin
      head_mid = '0;
      tail_mid = '0;
    end else begin
      head_mid = (host.pop_req && head != tail) ? ring_next(head) : head;
      tail_mid = tail;
    end
    push_ok       = push.valid && (ring_next(tail_mid) != head_mid);
    tail_next     = push_ok ? ring_next(tail_mid) : tail_mid;
    head_next     = head_mid;
    overflow_next = (host.clear_overflow ? 1'b0 : overflow_flag) | (push.valid && !push_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      tail          <= '0;
      overflow_flag <= 1'b0;
    end else if (fire) begin
      head          <= head_next;
      tail          <= tail_next;
      overflow_flag <= overflow_next;
    end
  end

  // Forward a byte written into the slot that becomes the head
  always_ff @(posedge clk) begin
    if (fire) begin
      if (push_ok) mem[tail_mid] <= push.data;
      rd_data <= (push_ok && tail_mid == head_mid) ? push.data : mem[head_mid];
    end
  end

  assign count = (tail >= head) ? ({1'b0, tail} - {1'b0, head})
                                : ({1'b0, tail} + DEPTH_W - {1'b0, head});

  assign status.rx_empty = (head == tail);
  assign status.rx_data  = status.rx_empty ? 8'h00 : rd_data;
  assign status.rx_count = 6'(count);
  assign status.overflow = overflow_flag;

  `ASSERT_IMPL(a_ovf_on_drop, $rose(overflow_flag), $past(fire && push.valid), "overflow set without a dropped item")

endmodule

FILE: hdl/uartpm_tx.sv
// 8N1 transmitter driven by per-tick bit delays.
`include "assert_macros.svh"

module uartpm_tx import uartpm_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             tx_valid,
  input  logic [7:0]       tx_byte,
  input  logic [CFG_W-1:0] tx_bit_ticks,
  output tx_status_t       status
);

  phase_t                phase, phase_mid, phase_next;
  logic [TIMER_BITS-1:0] timer, timer_next;
  logic [7:0]            shift, shift_next;
  logic [2:0]            bit_index, bit_index_next;
  logic                  accepted;
  logic                  timer_done;
  logic                  start;

  assign timer_done = (timer[TIMER_BITS-1:1] == '0);

  always_comb begin
    phase_mid = phase;
    unique case (phase)
      PH_IDLE:  phase_mid = PH_IDLE;
      PH_FIRST: if (timer_done) phase_mid = PH_DATA;
      PH_DATA:  if (timer_done && bit_index == 3'd7) phase_mid = PH_STOP;
      PH_STOP:  if (timer_done) phase_mid = PH_IDLE;
      default:  phase_mid = PH_IDLE;
    endcase
    // A new frame may follow on the tick the stop bit ends
    start      = (phase_mid == PH_IDLE) && tx_valid && (tx_bit_ticks != '0);
    phase_next = start ? PH_FIRST : phase_mid;
  end

  always_comb begin
    timer_next     = timer;
    shift_next     = shift;
    bit_index_next = bit_index;
    if (phase != PH_IDLE) begin
      if (timer_done) begin
        timer_next = TIMER_BITS'(tx_bit_ticks);
        if (phase == PH_FIRST) begin
          bit_index_next = '0;
        end else if (phase == PH_DATA && bit_index != 3'd7) begin
          bit_index_next = bit_index + 1'b1;
        end
      end else begin
        timer_next = timer - 1'b1;
      end
    end
    if (start) begin
      shift_next     = tx_byte;
      bit_index_next = '0;
      timer_next     = TIMER_BITS'(tx_bit_ticks);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      timer     <= '0;
      shift     <= '0;
      bit_index <= '0;
      accepted  <= 1'b0;
    end else if (fire) begin
      phase     <= phase_next;
      timer     <= timer_next;
      shift     <= shift_next;
      bit_index <= bit_index_next;
      accepted  <= start;
    end
  end

  always_comb begin
    unique case (phase)
      PH_FIRST: status.tx_line = 1'b0;
      PH_DATA:  status.tx_line = shift[bit_index];
      default:  status.tx_line = 1'b1;
    endcase
    status.tx_busy     = (phase != PH_IDLE);
    status.tx_accepted = accepted;
  end

  `ASSERT_IMPL(a_accept_starts, accepted, phase == PH_FIRST, "accepted byte did not open a frame")

endmodule

FILE: hdl/uart_rx_tx_fifo_pulse_meter.sv
// UART 8N1 with receive FIFO and long-low-pulse meter.
// Each item on the tick channel is one sampling tick: the receive line level,
// a byte offered for sending, and host requests (pop, flush, clear overflow,
// take width). Each accepted tick yields exactly one item on the result
// channel showing line, FIFO and meter state after that tick.
// The result is valid in the cycle after the tick is accepted.
// Throughput: one tick per cycle when not stalled; all per-tick work is a single
// pass from the state registers to their next values, and the FIFO head is read
// through a registered port of the byte store.
// The tick channel is ready whenever the result register is empty or is being
// taken, so a stalled receiver holds the result and pauses tick intake; no
// state advances without an accepted tick.
// Configuration: cfg_write with cfg_index and cfg_data writes a register at
// the clock edge; write only while no tick is in flight.
// Reset (synchronous, rst high): receiver and transmitter idle, FIFO empty,
// flags clear, registers at their reset values; no tick is taken during reset.
// There is no clearing pass: byte store contents are not reset.
`include "assert_macros.svh"

module uart_rx_tx_fifo_pulse_meter import uartpm_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst,
  uartpm_in_if.sink           tick,
  uartpm_out_if.source        result,
  input logic                 cfg_write,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data
);

  cfg_t         cfg;
  logic         fire;
  logic         res_valid;
  host_ctrl_t   host;
  push_t        push;
  fifo_status_t fifo_st;
  meter_t       meter;
  tx_status_t   tx_st;

  assign tick.ready = !rst && (!res_valid || result.ready);
  assign fire       = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rx_enable       <= 1'b0;
      cfg.rx_center_ticks <= RX_CENTER_RST;
      cfg.rx_bit_ticks    <= RX_BIT_RST;
      cfg.rx_stop_ticks   <= RX_STOP_RST;
      cfg.tx_bit_ticks    <= TX_BIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RX_ENABLE: cfg.rx_enable       <= cfg_data[0];
        CFG_RX_CENTER: cfg.rx_center_ticks <= cfg_data;
        CFG_RX_BIT:    cfg.rx_bit_ticks    <= cfg_data;
        CFG_RX_STOP:   cfg.rx_stop_ticks   <= cfg_data;
        CFG_TX_BIT:    cfg.tx_bit_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign host.pop_req        = tick.data.pop_req;
  assign host.flush          = tick.data.flush;
  assign host.clear_overflow = tick.data.clear_overflow;

  uartpm_rx #(
    .TIMER_BITS (TIMER_BITS)
  ) u_rx (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .rx_line    (tick.data.rx_line),
    .take_width (tick.data.take_width),
    .cfg        (cfg),
    .push       (push),
    .meter      (meter)
  );

  uartpm_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .host   (host),
    .push   (push),
    .status (fifo_st)
  );

  uartpm_tx #(
    .TIMER_BITS (TIMER_BITS)
  ) u_tx (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .tx_valid     (tick.data.tx_valid),
    .tx_byte      (tick.data.tx_byte),
    .tx_bit_ticks (cfg.tx_bit_ticks),
    .status       (tx_st)
  );

  assign result.valid            = res_valid;
  assign result.data.tx_line     = tx_st.tx_line;
  assign result.data.tx_accepted = tx_st.tx_accepted;
  assign result.data.tx_busy     = tx_st.tx_busy;
  assign result.data.rx_data     = fifo_st.rx_data;
  assign result.data.rx_empty    = fifo_st.rx_empty;
  assign result.data.rx_count    = fifo_st.rx_count;
  assign result.data.overflow    = fifo_st.overflow;
  assign result.data.pulse_width = meter.pulse_width;
  assign result.data.pulse_ready = meter.pulse_ready;

  `ASSERT_NEXT(a_tick_gives_result, fire, res_valid, "accepted tick left no result")

endmodule
